// File: hdl/mfbp_pkg.sv
// ----------------------------------------------------------------------------
// mfbp_pkg
// Shared types and codes for the msb-first bit packer: input modes, result
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mfbp_pkg;

  localparam logic [1:0] MODE_BITS   = 2'd0;
  localparam logic [1:0] MODE_ALIGN  = 2'd1;
  localparam logic [1:0] MODE_BYTE   = 2'd2;
  localparam logic [1:0] MODE_FINISH = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam int unsigned MAX_BYTES  = 9;
  localparam logic [6:0]  FIELD_MAX  = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_STEP,
    S_PUTB,
    S_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic fail_inv;
    logic fail_ovf;
    logic align;
    logic finish;
    logic step;
    logic put_byte;
    logic next;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       inv;
    logic       fast_ovf;
    logic       rem_zero;
    logic       last;
  } sts_t;

endpackage

// File: hdl/mfbp_ctrl.sv
// ----------------------------------------------------------------------------
// mfbp_ctrl
// Sequencer for the bit packer: takes an item, steers the datapath through
// its checks and byte steps, then hands out the buffered results.
// ----------------------------------------------------------------------------
module mfbp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  mfbp_pkg::sts_t sts,
  output mfbp_pkg::cmd_t cmd
);
  import mfbp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_PREP;
      end
      S_PREP: begin
        unique case (sts.mode)
          MODE_BITS:   state_nxt = (sts.inv || sts.fast_ovf) ? S_SEND : S_STEP;
          MODE_ALIGN:  state_nxt = S_SEND;
          MODE_BYTE:   state_nxt = S_PUTB;
          MODE_FINISH: state_nxt = S_SEND;
          default:     state_nxt = S_SEND;
        endcase
      end
      S_STEP: begin
        if (sts.rem_zero) state_nxt = S_SEND;
      end
      S_PUTB: state_nxt = S_SEND;
      S_SEND: begin
        if (out_tready && sts.last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_PREP: begin
        unique case (sts.mode)
          MODE_BITS: begin
            cmd.fail_inv = sts.inv;
            cmd.fail_ovf = !sts.inv && sts.fast_ovf;
          end
          MODE_ALIGN:  cmd.align  = 1'b1;
          MODE_BYTE:   cmd.align  = 1'b1;
          MODE_FINISH: cmd.finish = 1'b1;
          default:     cmd.align  = 1'b0;
        endcase
      end
      S_STEP: cmd.step = !sts.rem_zero;
      S_PUTB: cmd.put_byte = 1'b1;
      S_SEND: begin
        out_tvalid = 1'b1;
        cmd.next   = out_tready && !sts.last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: hdl/mfbp_dp.sv
// ----------------------------------------------------------------------------
// mfbp_dp
// Datapath for the bit packer: stream state, field shifter, byte merge,
// limit checks and the small buffer of completed bytes for one item.
// ----------------------------------------------------------------------------
module mfbp_dp #(
  parameter int unsigned CW = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data,
  input  logic [1:0]     in_mode,
  input  logic [63:0]    in_value,
  input  logic [6:0]     in_bit_count,
  input  mfbp_pkg::cmd_t cmd,
  output mfbp_pkg::sts_t sts,
  output logic [7:0]     res_byte,
  output logic           res_byte_valid,
  output logic [1:0]     res_status,
  output logic [16:0]    res_total
);
  import mfbp_pkg::*;

  localparam logic [CW+15:0] LIM_RST = {{CW{1'b0}}, 16'hFFFF};

  logic [CW-1:0] limit_r;
  logic [CW:0]   count_r, count_nxt;
  logic [7:0]    partial_r, partial_nxt;
  logic [2:0]    pos_r, pos_nxt;
  logic [6:0]    rem_r, rem_nxt;
  logic [63:0]   sh_r, sh_nxt;
  logic [6:0]    nbits_r;
  logic [1:0]    mode_r;
  logic [7:0]    byte_r;
  logic [1:0]    status_r, status_nxt;
  logic [CW:0]   total_r, total_nxt;
  logic [3:0]    nemit_r, nemit_nxt;
  logic [3:0]    rd_idx_r, rd_idx_nxt;
  logic [7:0]    buf_r [MAX_BYTES];

  logic [CW+15:0] cfg_ext;
  logic           room;
  logic [CW+1:0]  fast_sum;
  logic [3:0]     space;
  logic [3:0]     k;
  logic [7:0]     top;
  logic [7:0]     merged;
  logic [3:0]     pos_sum;
  logic [CW:0]    cur_total;
  logic [CW+17:0] tot_ext;
  logic           emit_en;
  logic [7:0]     emit_byte;

  assign cfg_ext   = {{CW{1'b0}}, cfg_wr_data};
  assign room      = count_r < {1'b0, limit_r};
  assign fast_sum  = {1'b0, count_r} + (CW+2)'(nbits_r[6:3]);
  assign cur_total = count_r + (CW+1)'(pos_r != 3'd0);

  assign space   = 4'd8 - {1'b0, pos_r};
  assign k       = (rem_r < {3'b000, space}) ? rem_r[3:0] : space;
  assign top     = sh_r[63:56] & ~(8'hFF >> k);
  assign merged  = partial_r | (top >> pos_r);
  assign pos_sum = {1'b0, pos_r} + k;

  always_comb begin
    count_nxt   = count_r;
    partial_nxt = partial_r;
    pos_nxt     = pos_r;
    rem_nxt     = rem_r;
    sh_nxt      = sh_r;
    status_nxt  = status_r;
    total_nxt   = total_r;
    nemit_nxt   = nemit_r;
    rd_idx_nxt  = rd_idx_r;
    emit_en     = 1'b0;
    emit_byte   = partial_r;
    if (cmd.load) begin
      sh_nxt     = in_value << (FIELD_MAX - in_bit_count);
      rem_nxt    = in_bit_count;
      status_nxt = ST_OK;
      nemit_nxt  = 4'd0;
      rd_idx_nxt = 4'd0;
    end else if (cmd.fail_inv) begin
      status_nxt = ST_INVALID;
    end else if (cmd.fail_ovf) begin
      status_nxt = ST_OVERFLOW;
    end else if (cmd.align) begin
      if (pos_r != 3'd0) begin
        emit_en     = 1'b1;
        count_nxt   = count_r + (CW+1)'(1);
        partial_nxt = 8'd0;
        pos_nxt     = 3'd0;
      end
    end else if (cmd.finish) begin
      total_nxt   = cur_total;
      emit_en     = pos_r != 3'd0;
      count_nxt   = '0;
      partial_nxt = 8'd0;
      pos_nxt     = 3'd0;
    end else if (cmd.put_byte) begin
      if (room) begin
        emit_en   = 1'b1;
        emit_byte = byte_r;
        count_nxt = count_r + (CW+1)'(1);
      end else begin
        status_nxt = ST_OVERFLOW;
      end
    end else if (cmd.step) begin
      if (room) begin
        sh_nxt  = sh_r << k;
        rem_nxt = rem_r - {3'b000, k};
        if (pos_sum == 4'd8) begin
          emit_en     = 1'b1;
          emit_byte   = merged;
          count_nxt   = count_r + (CW+1)'(1);
          partial_nxt = 8'd0;
          pos_nxt     = 3'd0;
        end else begin
          partial_nxt = merged;
          pos_nxt     = pos_sum[2:0];
        end
      end else begin
        status_nxt = ST_OVERFLOW;
        rem_nxt    = 7'd0;
      end
    end else if (cmd.next) begin
      rd_idx_nxt = rd_idx_r + 4'd1;
    end
    if (emit_en) nemit_nxt = nemit_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIM_RST[CW-1:0];
      count_r   <= '0;
      partial_r <= 8'd0;
      pos_r     <= 3'd0;
      rem_r     <= 7'd0;
      status_r  <= ST_OK;
      total_r   <= '0;
      nemit_r   <= 4'd0;
      rd_idx_r  <= 4'd0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_ext[CW-1:0];
      count_r   <= count_nxt;
      partial_r <= partial_nxt;
      pos_r     <= pos_nxt;
      rem_r     <= rem_nxt;
      status_r  <= status_nxt;
      total_r   <= total_nxt;
      nemit_r   <= nemit_nxt;
      rd_idx_r  <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
    if (cmd.load) begin
      mode_r  <= in_mode;
      nbits_r <= in_bit_count;
      byte_r  <= in_value[7:0];
    end
    if (emit_en) buf_r[nemit_r] <= emit_byte;
  end

  assign sts.mode     = mode_r;
  assign sts.inv      = nbits_r > FIELD_MAX;
  assign sts.fast_ovf = (pos_r == 3'd0) && (nbits_r >= 7'd8) &&
                        (fast_sum > (CW+2)'(limit_r));
  assign sts.rem_zero = rem_r == 7'd0;
  assign sts.last     = (nemit_r == 4'd0) || (rd_idx_r == nemit_r - 4'd1);

  assign tot_ext        = {17'd0, (mode_r == MODE_FINISH) ? total_r : cur_total};
  assign res_total      = tot_ext[16:0];
  assign res_byte_valid = nemit_r != 4'd0;
  assign res_byte       = res_byte_valid ? buf_r[rd_idx_r] : 8'd0;
  assign res_status     = status_r;

`ifndef SYNTHESIS
  a_nemit_max: assert property (@(posedge clk) disable iff (!rst_n)
    nemit_r <= 4'(MAX_BYTES))
    else $error("byte buffer overfilled");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= nemit_r)
    else $error("read index past buffered bytes");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (pos_r == 3'd0) && (count_r == '0) && (partial_r == 8'd0))
    else $error("stream state not cleared after finish");

  a_step_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !room) |=> (status_r == ST_OVERFLOW) && (rem_r == 7'd0))
    else $error("overflow on bit step not recorded");
`endif

endmodule

// File: hdl/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs fields of 0 to 64 bits, msb first, into a byte stream.
// ----------------------------------------------------------------------------
// in_* channel: one item per handshake; in_tuser is the mode (write bits,
// align, write aligned byte, finish), in_tdata carries value and bit count.
// out_* channel: one item per completed byte in stream order, or a single
// item without a byte when none completes; out_tlast marks the final one.
// Every result item of an input item carries its final status and total.
// cfg_wr_en/cfg_wr_data write the byte limit; write only while idle.
// Timing: an item is taken, checked in the next cycle, then a field in
// write-bits mode that passes the checks steps through each touched byte
// (up to 9) and closes, an aligned byte takes one more step; results
// follow at one per cycle while the receiver is ready. A new item is
// taken once the last result of the previous one has gone.
// A stalled receiver simply holds the current result on the outputs.
// Reset clears the stream (no partial byte, count zero), restores the byte
// limit to its maximum and leaves the block ready for a new item.
// ----------------------------------------------------------------------------
module msb_first_bit_packer #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // value[63:0], bit_count[70:64]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_byte[7:0], status[9:8], total_bytes[26:10]
  output logic        out_tuser,  // byte_valid
  output logic        out_tlast
);
  import mfbp_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [7:0]  res_byte;
  logic        res_byte_valid;
  logic [1:0]  res_status;
  logic [16:0] res_total;

  mfbp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mfbp_dp #(
    .CW (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_mode        (in_tuser),
    .in_value       (in_tdata[63:0]),
    .in_bit_count   (in_tdata[70:64]),
    .cmd            (cmd),
    .sts            (sts),
    .res_byte       (res_byte),
    .res_byte_valid (res_byte_valid),
    .res_status     (res_status),
    .res_total      (res_total)
  );

  assign out_tdata = {5'd0, res_total, res_status, res_byte};
  assign out_tuser = res_byte_valid;
  assign out_tlast = sts.last;

endmodule
